>>> hdl/hbw_pkg.sv
// Shared types and constants for the box-window corner response unit.
// No dependencies.
package hbw_pkg;

   localparam int RESP_W  = 51;
   localparam int COORD_W = 10;
   localparam int ROW_W   = 11;
   localparam int DIM_W   = 11;
   localparam int WIN_CFG_W = 3;
   localparam int ALPHA_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_HEIGHT = 1024;
   localparam int FRAC_BITS  = 16;

   localparam logic [DIM_W-1:0]     WIDTH_RST  = DIM_W'(640);
   localparam logic [DIM_W-1:0]     HEIGHT_RST = DIM_W'(480);
   localparam logic [WIN_CFG_W-1:0] WIN_RST    = WIN_CFG_W'(3);
   localparam logic [ALPHA_W-1:0]   ALPHA_RST  = ALPHA_W'(2621);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_WINDOW_SIZE  = 2'd2,
      CSR_ALPHA        = 2'd3
   } csr_index_type;

endpackage

>>> hdl/hbw_req_if.sv
// Gradient item channel: valid/ready handshake plus gradient pair.
// Uses no package.
interface hbw_req_if #(parameter int GRAD_BITS = 10);
   logic                        valid;
   logic                        ready;
   logic signed [GRAD_BITS-1:0] grad_x;
   logic signed [GRAD_BITS-1:0] grad_y;
   modport source (output valid, output grad_x, output grad_y, input ready);
   modport sink   (input valid, input grad_x, input grad_y, output ready);
endinterface

>>> hdl/hbw_rsp_if.sv
// Response item channel: valid/ready handshake plus response payload.
// Depends on hbw_pkg.
interface hbw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [hbw_pkg::RESP_W-1:0]  response;
   logic [hbw_pkg::COORD_W-1:0]        pixel_col;
   logic [hbw_pkg::COORD_W-1:0]        pixel_row;
   logic                               frame_end;
   modport source (output valid, output response, output pixel_col, output pixel_row,
                   output frame_end, input ready);
   modport sink   (input valid, input response, input pixel_col, input pixel_row,
                   input frame_end, output ready);
endinterface

>>> hdl/hbw_line_buffer.sv
// Gradient row store: one write port, one read port, registered read data.
// No package dependencies.
module hbw_line_buffer #(
   parameter int DATA_W = 20,
   parameter int DEPTH  = 7168
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/hbw_response.sv
// Four-stage arithmetic: A*B - C*C - floor(alpha*(A+B)^2 / 2^16), 51-bit wrap.
// Depends on hbw_pkg.
module hbw_response #(
   parameter int ACC_W = 25,
   parameter int XY_W  = 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ACC_W-1:0]              sum_xx,
   input  logic [ACC_W-1:0]              sum_yy,
   input  logic signed [XY_W-1:0]        sum_xy,
   input  logic [hbw_pkg::ALPHA_W-1:0]   alpha,
   output logic                          done,
   output logic signed [hbw_pkg::RESP_W-1:0] response
);
   import hbw_pkg::*;

   localparam int TR_W = ACC_W + 1;
   localparam int T2_W = 2 * TR_W;
   localparam int LO_W = T2_W / 2;
   localparam int HI_W = T2_W - LO_W;
   localparam int SC_W = T2_W + ALPHA_W;

   logic [3:0]               stage_ff;
   logic [3:0]               stage_in;
   logic [2*ACC_W-1:0]       ab_ff;
   logic signed [2*XY_W-1:0] cc_ff;
   logic [T2_W-1:0]          t2_ff;
   logic [TR_W-1:0]          tr;
   logic [RESP_W-1:0]        d_ff, d3_ff, resp_ff;
   logic [HI_W+ALPHA_W-1:0]  mhi_ff;
   logic [LO_W+ALPHA_W-1:0]  mlo_ff;
   logic [SC_W-1:0]          scaled_ff;
   logic [SC_W-1:0]          sc_sum;

   assign stage_in = {stage_ff[2:0], start};
   assign tr       = TR_W'(sum_xx) + TR_W'(sum_yy);
   assign sc_sum   = (SC_W'(mhi_ff) << LO_W) + SC_W'(mlo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      ab_ff     <= (2*ACC_W)'(sum_xx) * (2*ACC_W)'(sum_yy);
      cc_ff     <= (2*XY_W)'(sum_xy) * (2*XY_W)'(sum_xy);
      t2_ff     <= T2_W'(tr) * T2_W'(tr);
      d_ff      <= RESP_W'(ab_ff) - RESP_W'(cc_ff);
      mhi_ff    <= (HI_W+ALPHA_W)'(alpha) * (HI_W+ALPHA_W)'(t2_ff[T2_W-1:LO_W]);
      mlo_ff    <= (LO_W+ALPHA_W)'(alpha) * (LO_W+ALPHA_W)'(t2_ff[LO_W-1:0]);
      d3_ff     <= d_ff;
      scaled_ff <= sc_sum >> FRAC_BITS;
      resp_ff   <= d3_ff - RESP_W'(scaled_ff);
   end

   assign done     = stage_ff[3];
   assign response = $signed(resp_ff);
endmodule

>>> hdl/harris_box_window_corner_response_unit.sv
// Top level of the box-window corner response unit.
// Depends on hbw_pkg, hbw_req_if, hbw_rsp_if, hbw_line_buffer, hbw_response.
//
// The unit takes one gradient pair per item in extended raster order (rows of
// image_width+t positions, image_height+t rows, t = win-1-win/2 with win the
// clamped box side), stores it in a line memory of MAX_WINDOW rows and, once the
// box of a pixel is complete, emits A*B - C*C - floor(alpha*(A+B)^2/2^16) for that
// pixel. An item with no response leaves the unit idle for the next item; an item
// with a response goes through the accept, win^2 tap reads through the single read
// port of the line memory (one gradient pair per cycle summed), a drain step for the
// last read, the start register and the four-stage arithmetic, and the load of the
// output register. A receiver that holds off stalls the unit before that load. One
// item is worked on at a time. Registers may be written only when the unit is idle;
// an out-of-range width, height or window is clamped.
module harris_box_window_corner_response_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_WINDOW = 7,
   parameter int GRAD_BITS  = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   hbw_req_if.sink                         req_chan,
   hbw_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [hbw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hbw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hbw_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH + MAX_WINDOW + 1);
   localparam int CMP_W  = (COL_W > DIM_W + 1) ? COL_W : DIM_W + 1;
   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int WK_W   = (WIN_W > WIN_CFG_W) ? WIN_W : WIN_CFG_W;
   localparam int SLOT_W = $clog2(MAX_WINDOW + 1);
   localparam int SD_W   = ((SLOT_W > WK_W) ? SLOT_W : WK_W) + 1;
   localparam int ADDR_W = $clog2(MAX_WINDOW * MAX_WIDTH);
   localparam int SQ_W   = 2 * GRAD_BITS;
   localparam int ACC_W  = SQ_W - 1 + $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int XY_W   = ACC_W + 1;

   typedef enum logic [2:0] {ST_IDLE, ST_SUM, ST_DRAIN, ST_CALC, ST_OUT} state_type;

   // configuration
   logic [DIM_W-1:0]     width_ff, height_ff;
   logic [WIN_CFG_W-1:0] win_cfg_ff;
   logic [ALPHA_W-1:0]   alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RST;
         height_ff  <= HEIGHT_RST;
         win_cfg_ff <= WIN_RST;
         alpha_ff   <= ALPHA_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_wdata[DIM_W-1:0];
            CSR_WINDOW_SIZE:  win_cfg_ff <= csr_wdata[WIN_CFG_W-1:0];
            CSR_ALPHA:        alpha_ff   <= csr_wdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped geometry
   logic [COL_W-1:0] eff_w, lim_w;
   logic [ROW_W-1:0] eff_h, lim_h;
   logic [WK_W-1:0]  win, half, tail;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = COL_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         eff_w = COL_W'(MAX_WIDTH);
      end else begin
         eff_w = COL_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (height_ff > ROW_W'(MAX_HEIGHT)) begin
         eff_h = ROW_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
      if (win_cfg_ff == '0) begin
         win = WK_W'(1);
      end else if (WK_W'(win_cfg_ff) > WK_W'(MAX_WINDOW)) begin
         win = WK_W'(MAX_WINDOW);
      end else begin
         win = WK_W'(win_cfg_ff);
      end
      half  = win >> 1;
      tail  = win - WK_W'(1) - half;
      lim_w = eff_w + COL_W'(tail);
      lim_h = eff_h + ROW_W'(tail);
   end

   // control and working registers
   state_type        state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [COL_W-1:0] px_ff, px_in;
   logic [ROW_W-1:0] py_ff, py_in;
   logic [WK_W-1:0]  wi_ff, wi_in, wj_ff, wj_in;
   logic             tag_ff, tag_in;
   logic             out_valid_ff, out_valid_in;
   logic [ACC_W-1:0] acc_xx_ff, acc_xx_in, acc_yy_ff, acc_yy_in;
   logic signed [XY_W-1:0] acc_xy_ff, acc_xy_in;
   logic signed [RESP_W-1:0] out_resp_ff, out_resp_in;
   logic [COORD_W-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic             out_end_ff, out_end_in;

   // accept-time position after wrap
   logic [COL_W-1:0]  c0, nc;
   logic [ROW_W-1:0]  r0, nr;
   logic [SLOT_W-1:0] s0;
   logic              accept, wr_en, emit;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // window read address
   logic signed [ROW_W+1:0] yy;
   logic signed [COL_W+1:0] xx;
   logic signed [SD_W-1:0]  sdiff;
   logic [SLOT_W-1:0]       rslot;
   logic                    in_box, last_tap;

   // memory read data and products
   logic [SQ_W-1:0]                 rd_data;
   logic signed [GRAD_BITS-1:0]     rd_gx, rd_gy;
   logic signed [SQ_W-1:0]          pxx, pyy, pxy;

   logic                      calc_start_ff, calc_start_in, calc_done;
   logic signed [RESP_W-1:0]  calc_resp;

   assign accept = req_chan.valid && (state_ff == ST_IDLE);
   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      c0 = (col_ff >= lim_w) ? '0 : col_ff;
      r0 = (row_ff >= lim_h) ? '0 : row_ff;
      s0 = (row_ff >= lim_h) ? '0 : slot_ff;
      wr_en   = accept && (c0 < eff_w) && (r0 < eff_h);
      emit    = (c0 >= COL_W'(tail)) && (r0 >= ROW_W'(tail));
      wr_addr = ADDR_W'(s0) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c0);
      nc = c0 + COL_W'(1);
      nr = r0 + ROW_W'(1);
   end

   // box tap (wi, wj): row py-half+wi, column px-half+wj; the row's slot is
   // counted back from the slot of the newest row
   always_comb begin
      yy = $signed({2'b00, py_ff}) - $signed((ROW_W+2)'(half)) + $signed((ROW_W+2)'(wi_ff));
      xx = $signed({2'b00, px_ff}) - $signed((COL_W+2)'(half)) + $signed((COL_W+2)'(wj_ff));
      in_box = (yy >= 0) && (yy < $signed({2'b00, eff_h}))
            && (xx >= 0) && (xx < $signed({2'b00, eff_w}));
      sdiff = $signed(SD_W'(cur_slot_ff)) - $signed(SD_W'(win - WK_W'(1) - wi_ff));
      if (sdiff < 0) begin
         sdiff = sdiff + $signed(SD_W'(MAX_WINDOW));
      end
      rslot   = SLOT_W'(sdiff);
      rd_addr = ADDR_W'(rslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xx[COL_W-1:0]);
      last_tap = (wi_ff == win - WK_W'(1)) && (wj_ff == win - WK_W'(1));
   end

   hbw_line_buffer #(
      .DATA_W (SQ_W),
      .DEPTH  (MAX_WINDOW * MAX_WIDTH)
   ) u_lbuf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_chan.grad_x, req_chan.grad_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_gx = $signed(rd_data[SQ_W-1:GRAD_BITS]);
   assign rd_gy = $signed(rd_data[GRAD_BITS-1:0]);
   assign pxx = SQ_W'(rd_gx) * SQ_W'(rd_gx);
   assign pyy = SQ_W'(rd_gy) * SQ_W'(rd_gy);
   assign pxy = SQ_W'(rd_gx) * SQ_W'(rd_gy);

   // the last tap lands during drain, so the sums are final in the cycle after it
   assign calc_start_in = (state_ff == ST_DRAIN);

   hbw_response #(
      .ACC_W (ACC_W),
      .XY_W  (XY_W)
   ) u_resp (
      .clock    (clock),
      .reset    (reset),
      .start    (calc_start_ff),
      .sum_xx   (acc_xx_ff),
      .sum_yy   (acc_yy_ff),
      .sum_xy   (acc_xy_ff),
      .alpha    (alpha_ff),
      .done     (calc_done),
      .response (calc_resp)
   );

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      slot_in      = slot_ff;
      cur_slot_in  = cur_slot_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      wi_in        = wi_ff;
      wj_in        = wj_ff;
      tag_in       = 1'b0;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      acc_xx_in    = acc_xx_ff;
      acc_yy_in    = acc_yy_ff;
      acc_xy_in    = acc_xy_ff;
      out_resp_in  = out_resp_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_end_in   = out_end_ff;

      // tap read in the previous cycle lands now
      if (tag_ff) begin
         acc_xx_in = acc_xx_ff + ACC_W'($unsigned(pxx));
         acc_yy_in = acc_yy_ff + ACC_W'($unsigned(pyy));
         acc_xy_in = acc_xy_ff + XY_W'(pxy);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_slot_in = s0;
               px_in = c0 - COL_W'(tail);
               py_in = r0 - ROW_W'(tail);
               wi_in = '0;
               wj_in = '0;
               acc_xx_in = '0;
               acc_yy_in = '0;
               acc_xy_in = '0;
               if (nc >= lim_w) begin
                  col_in = '0;
                  if (nr >= lim_h) begin
                     row_in  = '0;
                     slot_in = '0;
                  end else begin
                     row_in  = nr;
                     slot_in = (s0 == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s0 + SLOT_W'(1);
                  end
               end else begin
                  col_in  = nc;
                  row_in  = r0;
                  slot_in = s0;
               end
               if (emit) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            tag_in = in_box;
            if (last_tap) begin
               state_in = ST_DRAIN;
            end else if (wj_ff == win - WK_W'(1)) begin
               wj_in = '0;
               wi_in = wi_ff + WK_W'(1);
            end else begin
               wj_in = wj_ff + WK_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (calc_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free; sums stay put, so the
            // arithmetic keeps presenting the same result
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_resp_in  = calc_resp;
               out_col_in   = COORD_W'(px_ff);
               out_row_in   = COORD_W'(py_ff);
               out_end_in   = (px_ff == eff_w - COL_W'(1)) && (py_ff == eff_h - ROW_W'(1));
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         slot_ff       <= '0;
         tag_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         calc_start_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         slot_ff       <= slot_in;
         tag_ff        <= tag_in;
         out_valid_ff  <= out_valid_in;
         calc_start_ff <= calc_start_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_slot_ff <= cur_slot_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      wi_ff       <= wi_in;
      wj_ff       <= wj_in;
      acc_xx_ff   <= acc_xx_in;
      acc_yy_ff   <= acc_yy_in;
      acc_xy_ff   <= acc_xy_in;
      out_resp_ff <= out_resp_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.response  = out_resp_ff;
   assign rsp_chan.pixel_col = out_col_ff;
   assign rsp_chan.pixel_row = out_row_ff;
   assign rsp_chan.frame_end = out_end_ff;
endmodule

>>> test/tb_top.sv
// Self-checking testbench for harris_box_window_corner_response_unit.
// Depends on hbw_pkg, hbw_req_if, hbw_rsp_if and the unit itself.
`timescale 1ns / 100ps

module tb_top;
   import hbw_pkg::*;

   localparam int NROWS = 7;     // line store depth in rows (MAX_WINDOW)
   localparam int NCOLS = 1024;  // MAX_WIDTH

   typedef struct {
      logic signed [RESP_W-1:0] response;
      logic [COORD_W-1:0]       col;
      logic [COORD_W-1:0]       row;
      logic                     frame_end;
   } corner_type;

   // directed row: one single-pixel frame per row
   typedef struct {
      logic [ALPHA_W-1:0]  alpha;
      logic signed [9:0]   gx;
      logic signed [9:0]   gy;
      bit                  known;
      longint              value;
   } pixel_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hbw_req_if #(.GRAD_BITS(10)) req_chan ();
   hbw_rsp_if                   rsp_chan ();

   harris_box_window_corner_response_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------------
   // Predictor state: own copy of registers, line store and raster position
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0]     cfg_width;
   logic [DIM_W-1:0]     cfg_height;
   logic [WIN_CFG_W-1:0] cfg_window;
   logic [ALPHA_W-1:0]   cfg_alpha;
   logic signed [9:0]    line_gx [0:NROWS-1][0:NCOLS-1];
   logic signed [9:0]    line_gy [0:NROWS-1][0:NCOLS-1];
   int                   pos_col;
   int                   pos_row;

   corner_type pending_corners[$];
   int      error_count;
   bit      send_gaps;      // sender idles at random
   bit      recv_stalls;    // receiver stalls at random
   bit      hold_request;   // ask the receiver for one long hold-off
   int      random_items;

   // Advance the raster by one item; returns 1 when a response is due.
   function automatic bit predict_corner(input logic signed [9:0] gx,
                                         input logic signed [9:0] gy,
                                         output corner_type res);
      int w, hg, win, hh, t, c, r, px, py;
      longint sxx, syy, sxy;
      logic [63:0]  trace;
      logic [127:0] trace_sq, scaled;
      logic [63:0]  resp;
      bit emit;
      w   = (cfg_width  < 1) ? 1 : (cfg_width  > NCOLS) ? NCOLS : cfg_width;
      hg  = (cfg_height < 1) ? 1 : (cfg_height > 1024)  ? 1024  : cfg_height;
      win = (cfg_window < 1) ? 1 : cfg_window;
      hh  = win / 2;
      t   = win - 1 - hh;
      // counters wrap if a config change left them past the extended raster
      if (pos_col >= w + t) pos_col = 0;
      if (pos_row >= hg + t) pos_row = 0;
      c = pos_col;
      r = pos_row;
      if (c < w && r < hg) begin
         line_gx[r % NROWS][c] = gx;
         line_gy[r % NROWS][c] = gy;
      end
      emit = (c >= t && r >= t);
      res = '{default: '0};
      if (emit) begin
         px = c - t;
         py = r - t;
         sxx = 0; syy = 0; sxy = 0;
         for (int yy = py - hh; yy <= py + t; yy++) begin
            if (yy < 0 || yy >= hg) continue;
            for (int xx = px - hh; xx <= px + t; xx++) begin
               if (xx < 0 || xx >= w) continue;
               sxx += longint'(line_gx[yy % NROWS][xx]) * longint'(line_gx[yy % NROWS][xx]);
               syy += longint'(line_gy[yy % NROWS][xx]) * longint'(line_gy[yy % NROWS][xx]);
               sxy += longint'(line_gx[yy % NROWS][xx]) * longint'(line_gy[yy % NROWS][xx]);
            end
         end
         trace    = 64'(sxx + syy);
         trace_sq = 128'(trace) * 128'(trace);
         scaled   = (128'(cfg_alpha) * trace_sq) >> FRAC_BITS;
         resp     = 64'(sxx * syy - sxy * sxy) - scaled[63:0];
         res.response  = resp[RESP_W-1:0];
         res.col       = px[COORD_W-1:0];
         res.row       = py[COORD_W-1:0];
         res.frame_end = (px == w - 1 && py == hg - 1);
      end
      pos_col = c + 1;
      if (pos_col >= w + t) begin
         pos_col = 0;
         pos_row = r + 1;
         if (pos_row >= hg + t) pos_row = 0;
      end
      return emit;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // Offer one item; returns once accepted. Expected corner is queued on
   // acceptance unless the caller supplies its own.
   task automatic send_gradient(input logic signed [9:0] gx, input logic signed [9:0] gy,
                                input bit use_typed = 0,
                                input corner_type typed = '{default: '0});
      int gap;
      corner_type res;
      gap = 0;
      if (send_gaps) begin
         case ($urandom_range(0, 19))
            0:             gap = $urandom_range(10, 40);
            1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
            default:       gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.grad_x <= gx;
      req_chan.grad_y <= gy;
      do @(posedge clock); while (!req_chan.ready);
      if (predict_corner(gx, gy, res))
         pending_corners.push_back(use_typed ? typed : res);
   endtask

   function automatic logic signed [9:0] random_grad();
      case ($urandom_range(0, 9))
         0:       return -10'sd512;
         1:       return 10'sd511;
         default: return 10'($urandom);
      endcase
   endfunction

   // Stream items until the raster is back at its origin.
   task automatic finish_frame();
      do begin
         send_gradient(random_grad(), random_grad());
         random_items++;
      end while (pos_col != 0 || pos_row != 0);
   endtask

   // Wait for every expected corner, then for any items still in flight.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_corners.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Unit must be idle. Writes all four registers, one per cycle.
   task automatic write_config(input int w, input int h, input int win, input int a);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= CSR_WINDOW_SIZE;
      csr_wdata <= CSR_DATA_W'(win);
      @(posedge clock);
      csr_index <= CSR_ALPHA;
      csr_wdata <= CSR_DATA_W'(a);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_width  = DIM_W'(w);
      cfg_height = DIM_W'(h);
      cfg_window = WIN_CFG_W'(win);
      cfg_alpha  = ALPHA_W'(a);
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: random stalls, one long hold-off on request, checking
   // ---------------------------------------------------------------------
   initial begin
      int stall_left;
      corner_type exp_c;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_corners.size() == 0) begin
               $display("%0t: unexpected response %0d at (%0d,%0d)", $time,
                        rsp_chan.response, rsp_chan.pixel_col, rsp_chan.pixel_row);
               error_count++;
            end else begin
               exp_c = pending_corners.pop_front();
               if (rsp_chan.response !== exp_c.response) begin
                  $display("%0t: response expected %0d actual %0d", $time,
                           exp_c.response, rsp_chan.response);
                  error_count++;
               end
               if (rsp_chan.pixel_col !== exp_c.col) begin
                  $display("%0t: pixel_col expected %0d actual %0d", $time,
                           exp_c.col, rsp_chan.pixel_col);
                  error_count++;
               end
               if (rsp_chan.pixel_row !== exp_c.row) begin
                  $display("%0t: pixel_row expected %0d actual %0d", $time,
                           exp_c.row, rsp_chan.pixel_row);
                  error_count++;
               end
               if (rsp_chan.frame_end !== exp_c.frame_end) begin
                  $display("%0t: frame_end expected %0b actual %0b", $time,
                           exp_c.frame_end, rsp_chan.frame_end);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 0;
            stall_left = 400;   // long enough for the sender to back up
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (recv_stalls && $urandom_range(0, 7) == 0)
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   // Single-pixel frames (1x1, window 1). Alpha 0 gives det = 0 for one pixel;
   // full-scale alpha on -512/-512 gives -(65535 * 2^22).
   pixel_row_type pixel_table[] = '{
      '{16'd0,     -10'sd512, -10'sd512, 1, 0},
      '{16'd0,      10'sd511, -10'sd512, 1, 0},
      '{16'd0,      10'sd511,  10'sd511, 1, 0},
      '{16'd65535,  10'sd0,    10'sd0,   1, 0},
      '{16'd65535, -10'sd512, -10'sd512, 1, -64'sd274873712640},
      '{16'd65535,  10'sd511,  10'sd511, 0, 0},
      '{16'd65535, -10'sd512,  10'sd511, 0, 0},
      '{16'd2621,   10'sd1,    10'sd0,   1, 0},
      '{16'd2621,  -10'sd1,   -10'sd1,   0, 0},
      '{16'd40000,  10'sd300, -10'sd77,  0, 0}
   };

   initial begin
      corner_type typed;
      int w, h, win, a;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_IMAGE_WIDTH;
      csr_wdata      <= '0;
      req_chan.valid <= 1'b0;
      req_chan.grad_x <= '0;
      req_chan.grad_y <= '0;
      error_count  = 0;
      random_items = 0;
      send_gaps    = 0;
      recv_stalls  = 0;
      hold_request = 0;
      pos_col = 0;
      pos_row = 0;
      cfg_width  = WIDTH_RST;
      cfg_height = HEIGHT_RST;
      cfg_window = WIN_RST;
      cfg_alpha  = ALPHA_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single-pixel frames
      foreach (pixel_table[i]) begin
         write_config(1, 1, 1, pixel_table[i].alpha);
         typed = '{response: RESP_W'(pixel_table[i].value), col: '0, row: '0,
                   frame_end: 1'b1};
         send_gradient(pixel_table[i].gx, pixel_table[i].gy, pixel_table[i].known, typed);
         drain();
      end

      // clamps: zero width, height and window all act as 1
      write_config(0, 0, 0, 2621);
      send_gradient(10'sd100, -10'sd100);
      drain();

      // largest window on a small frame, with the receiver held off
      write_config(8, 8, 7, 65535);
      send_gaps   = 1;
      recv_stalls = 1;
      hold_request = 1;
      finish_frame();
      drain();

      // mid-frame change to a smaller raster: counters wrap, old lines reused
      write_config(8, 8, 7, 2621);
      repeat (30) send_gradient(random_grad(), random_grad());
      drain();
      write_config(5, 4, 5, 30000);
      finish_frame();
      drain();

      // random frames, mostly small
      random_items = 0;
      while (random_items < 360) begin
         w   = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
         h   = $urandom_range(1, 10);
         win = $urandom_range(0, 7);
         case ($urandom_range(0, 5))
            0:       a = 0;
            1:       a = 65535;
            default: a = $urandom_range(0, 65535);
         endcase
         send_gaps   = ($urandom_range(0, 3) != 0);
         recv_stalls = ($urandom_range(0, 3) != 0);
         write_config(w, h, win, a);
         finish_frame();
         drain();
      end

      drain();
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // hard stop in case the unit hangs
   initial begin
      #20000000;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
hdl/hbw_pkg.sv
hdl/hbw_req_if.sv
hdl/hbw_rsp_if.sv
hdl/hbw_line_buffer.sv
hdl/hbw_response.sv
hdl/harris_box_window_corner_response_unit.sv
test/tb_top.sv
